// File: hw/rtl/pida_pkg.sv
// Shared types and codes for the positional insert/delete array.
package pida_pkg;

  // Request kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic        [1:0]  kind;
    logic        [7:0]  position;
    logic signed [31:0] value;
  } req_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [5:0]  entry_index;
    logic signed [31:0] entry_value;
    logic        [6:0]  entry_count;
    logic               last;
  } rsp_item_t;

endpackage

// File: hw/rtl/pida_chan_if.sv
// Valid/ready channel carrying one payload item per beat.
interface pida_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/positional_insert_delete_array.sv
// Top level: bounded ordered list with positional insert, delete and dump.
//
//  channel | dir | payload                                          | beats per request
//  --------+-----+--------------------------------------------------+------------------
//  req     | in  | kind, position, value                            | 1
//  rsp     | out | status, entry_index, entry_value, entry_count,   | 1, or count for
//          |     | last                                             | a non-empty dump
//
// Sequencing: a request is taken in idle; an insert at slot s then moves count - s
// entries up, each by a read and then a write on the store, then writes the
// new value and posts the result. A delete moves count - pos entries down the
// same way and then posts. A dump reads each entry and then posts it. Errors
// post the result straight away, with no store access.
// Reset clears the count, the sequencer and the result valid flag; the store is
// not cleared and is only ever read below the count.
// A stalled rsp holds the sequencer in its posting state; req is not ready again
// until the last beat of the current request has been loaded into the result
// register.
module positional_insert_delete_array #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  pida_chan_if.sink   req,
  pida_chan_if.source rsp
);
  import pida_pkg::*;

  // Count width holds CAPACITY itself; address width indexes the store
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_RD   = 4'd1;
  localparam logic [3:0] S_INS_WR   = 4'd2;
  localparam logic [3:0] S_INS_PUT  = 4'd3;
  localparam logic [3:0] S_DEL_RD   = 4'd4;
  localparam logic [3:0] S_DEL_WR   = 4'd5;
  localparam logic [3:0] S_RESP     = 4'd6;
  localparam logic [3:0] S_DUMP_RD  = 4'd7;
  localparam logic [3:0] S_DUMP_OUT = 4'd8;

  // Entry store: one write port, one registered read port
  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd_data;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  // Sequencer registers
  logic [3:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      slot, slot_next;
  logic signed [31:0] ins_value, ins_value_next;
  logic [1:0]         status, status_next;

  // Result register
  logic      out_valid, out_valid_next;
  rsp_item_t out_data, out_data_next;
  logic      out_free;
  logic      out_load;

  // Shared index arithmetic
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_inc2;
  logic [7:0]    cnt8;
  logic [CW-1:0] pos_slot;
  logic          accept;

  assign idx_dec  = idx - CW'(1);
  assign idx_inc  = idx + CW'(1);
  assign idx_inc2 = idx + CW'(2);
  assign cnt8     = 8'(count);
  assign pos_slot = CW'(req.data.position - 8'd1);

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    slot_next      = slot;
    ins_value_next = ins_value;
    status_next    = status;
    mem_we         = 1'b0;
    mem_waddr      = idx[AW-1:0];
    mem_wdata      = rd_data;
    mem_re         = 1'b0;
    mem_raddr      = idx[AW-1:0];
    out_load       = 1'b0;
    out_data_next  = out_data;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          slot_next      = pos_slot;
          ins_value_next = req.data.value;
          status_next    = ST_OK;
          state_next     = S_RESP;
          case (req.data.kind)
            KIND_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                status_next = ST_FULL;
              end else if (req.data.position == 8'd0 ||
                           req.data.position > cnt8 + 8'd1) begin
                status_next = ST_BADPOS;
              end else if (count > pos_slot) begin
                // make room: move entries up from the top down
                idx_next   = count;
                state_next = S_INS_RD;
              end else begin
                state_next = S_INS_PUT;
              end
            end
            KIND_DELETE: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else if (req.data.position == 8'd0 ||
                           req.data.position > cnt8) begin
                status_next = ST_BADPOS;
              end else if (pos_slot + CW'(1) < count) begin
                // close the gap: move entries down from the slot up
                idx_next   = pos_slot;
                state_next = S_DEL_RD;
              end else begin
                count_next = count - CW'(1);
              end
            end
            KIND_DUMP: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                idx_next   = '0;
                state_next = S_DUMP_RD;
              end
            end
            default: begin
              status_next = ST_BADPOS;
            end
          endcase
        end
      end

      S_INS_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx_dec[AW-1:0];
        state_next = S_INS_WR;
      end

      S_INS_WR: begin
        mem_we     = 1'b1;
        idx_next   = idx_dec;
        state_next = (idx_dec == slot) ? S_INS_PUT : S_INS_RD;
      end

      S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = slot[AW-1:0];
        mem_wdata  = ins_value;
        count_next = count + CW'(1);
        state_next = S_RESP;
      end

      S_DEL_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx_inc[AW-1:0];
        state_next = S_DEL_WR;
      end

      S_DEL_WR: begin
        mem_we   = 1'b1;
        idx_next = idx_inc;
        if (idx_inc2 < count) begin
          state_next = S_DEL_RD;
        end else begin
          count_next = count - CW'(1);
          state_next = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load                  = 1'b1;
          out_data_next.status      = status;
          out_data_next.entry_index = '0;
          out_data_next.entry_value = '0;
          out_data_next.entry_count = 7'(count);
          out_data_next.last        = 1'b1;
          state_next                = S_IDLE;
        end
      end

      S_DUMP_RD: begin
        mem_re     = 1'b1;
        state_next = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        // rd_data holds until the next read, so a stall just waits here
        if (out_free) begin
          out_load                  = 1'b1;
          out_data_next.status      = ST_OK;
          out_data_next.entry_index = 6'(idx);
          out_data_next.entry_value = rd_data;
          out_data_next.entry_count = 7'(count);
          out_data_next.last        = (idx_inc == count);
          idx_next                  = idx_inc;
          state_next                = (idx_inc == count) ? S_IDLE : S_DUMP_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    slot      <= slot_next;
    ins_value <= ins_value_next;
    status    <= status_next;
    out_data  <= out_data_next;
  end

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A request closes the input until the sequencer returns to idle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while another is in progress");

  // Count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> (count == $past(count) ||
                         count == $past(count) + CW'(1) ||
                         count == $past(count) - CW'(1)))
    else $error("entry count jumped");

  // Every non-ok result closes its request
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status != ST_OK |-> rsp.data.last)
    else $error("error result without last");

endmodule
